@@ rtl/up_down_stopwatch_seven_segment_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Stopwatch assertion macros
// Shared concurrent assertion shorthands, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef UP_DOWN_STOPWATCH_SEVEN_SEGMENT_UNIT_DEFINES_SVH
`define UP_DOWN_STOPWATCH_SEVEN_SEGMENT_UNIT_DEFINES_SVH

// Same-cycle implication
`define USW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define USW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/usw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch package
// Types, button codes and the seven-segment pattern table of the stopwatch.
// ----------------------------------------------------------------------------
package usw_pkg;

	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned PRESCALE_W = 20;
	localparam int unsigned SEG_W      = 7;
	localparam int unsigned ENABLE_W   = 8;
	localparam int unsigned WORD_W     = SEG_W + ENABLE_W;
	localparam int unsigned CODE_W     = 5;
	localparam int unsigned POS_W      = 3;

	localparam logic [PRESCALE_W-1:0] CLOCKS_PER_UNIT_RST = 20'd10000;

	// Button codes, one bit each
	localparam logic [CODE_W-1:0] BTN_UP    = 5'd1;
	localparam logic [CODE_W-1:0] BTN_START = 5'd2;
	localparam logic [CODE_W-1:0] BTN_STOP  = 5'd4;
	localparam logic [CODE_W-1:0] BTN_DOWN  = 5'd8;
	localparam logic [CODE_W-1:0] BTN_RESET = 5'd16;

	localparam logic KIND_TICK = 1'b0;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Command broadcast to every digit cell
	typedef struct packed {
		logic up;
		logic dn;
		logic clr;
	} usw_cmd_t;

	// Signals handed from one cell to the next, least significant first
	typedef struct packed {
		logic carry;     // this cell steps (carry or borrow from below)
		logic zero;      // all lower digits are zero now
		logic nxt_zero;  // all lower digits are zero after the update
	} usw_link_t;

	typedef struct packed {
		logic [WORD_W-1:0] drive_word;
		logic              running;
		logic              counting_up;
	} usw_result_t;

	// Active-high segments g..a of a BCD digit; codes above nine show zero
	function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
		logic [SEG_W-1:0] s;
		begin
			case (d)
				4'd0:    s = 7'b0111111;
				4'd1:    s = 7'b0000110;
				4'd2:    s = 7'b1011011;
				4'd3:    s = 7'b1001111;
				4'd4:    s = 7'b1100110;
				4'd5:    s = 7'b1101101;
				4'd6:    s = 7'b1111101;
				4'd7:    s = 7'b0000111;
				4'd8:    s = 7'b1111111;
				4'd9:    s = 7'b1101111;
				default: s = 7'b0111111;
			endcase
			return s;
		end
	endfunction

endpackage

@@ rtl/usw_digit_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch digit cell
// One BCD digit of the time; steps up or down when the carry from below
// reaches it and passes carry and zero flags to the next digit.
// ----------------------------------------------------------------------------
module usw_digit_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  usw_pkg::usw_cmd_t   cmd,
	input  usw_pkg::usw_link_t  link_in,
	output usw_pkg::usw_link_t  link_out,
	output usw_pkg::digit_t     value
);
	import usw_pkg::*;

	digit_t digit_q;
	digit_t digit_nxt;

	// Work out the next digit and the carry or borrow to pass on
	always_comb begin
		digit_nxt      = digit_q;
		link_out.carry = 1'b0;
		if (cmd.clr) begin
			digit_nxt = '0;
		end else if (link_in.carry && cmd.up) begin
			if (digit_q >= 4'd9) begin
				digit_nxt      = '0;
				link_out.carry = 1'b1;
			end else begin
				digit_nxt = digit_q + 4'd1;
			end
		end else if (link_in.carry && cmd.dn) begin
			if (digit_q == 4'd0) begin
				digit_nxt      = 4'd9;
				link_out.carry = 1'b1;
			end else begin
				digit_nxt = digit_q - 4'd1;
			end
		end
		link_out.zero     = link_in.zero && (digit_q == 4'd0);
		link_out.nxt_zero = link_in.nxt_zero && (digit_nxt == 4'd0);
	end

	assign value = digit_nxt;

	// Hold the digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			digit_q <= digit_nxt;
		end
	end

endmodule

@@ rtl/up_down_stopwatch_seven_segment_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Up/down stopwatch with seven-segment drive
// BCD stopwatch in 0.1 ms units with a prescaler and active-low display word.
// ----------------------------------------------------------------------------
// The unit takes one word every clock while item_stall is low: a tick of the
// time base or a button event. The whole state update for a word (prescaler,
// start/stop, direction and the ripple through the row of NUM_DIGITS digit
// cells) settles in the cycle the word is accepted; the display word for the
// chosen digit position, taken after that update, goes into an output register
// backed by a skid register, which keeps taking words while a result waits;
// item_stall rises only when both are full. The user writes clocks_per_unit
// (wr_en/wr_data) only while no word is in flight; the block does not check.
// ----------------------------------------------------------------------------
`include "up_down_stopwatch_seven_segment_unit_defines.svh"

module up_down_stopwatch_seven_segment_unit #(
	parameter int unsigned NUM_DIGITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            wr_en,
	input  logic [usw_pkg::PRESCALE_W-1:0]  wr_data,
	// input words
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            kind,
	input  logic [usw_pkg::CODE_W-1:0]      button_code,
	input  logic [usw_pkg::POS_W-1:0]       digit_position,
	// result words
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [usw_pkg::WORD_W-1:0]      drive_word,
	output logic                            running,
	output logic                            counting_up
);
	import usw_pkg::*;

	logic [PRESCALE_W-1:0] clocks_per_unit_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic [PRESCALE_W-1:0] prescale_nxt;
	logic [PRESCALE_W-1:0] limit;
	logic [PRESCALE_W-1:0] pc_inc;
	logic                  is_running_q;
	logic                  is_running_nxt;
	logic                  dir_up_q;
	logic                  dir_up_nxt;

	logic                  accept;
	logic                  tick_acc;
	logic                  btn_acc;
	logic                  step;

	usw_cmd_t              cmd;
	usw_link_t             links [NUM_DIGITS+1];
	digit_t                values [NUM_DIGITS];
	digit_t                shown;
	logic [SEG_W-1:0]      segs;
	usw_result_t           result_new;

	usw_result_t           out_q;
	usw_result_t           skid_q;
	logic                  out_vld_q;
	logic                  skid_vld_q;
	logic                  out_load;

	assign item_stall = skid_vld_q;
	assign accept     = item_valid && !item_stall;
	assign tick_acc   = accept && (kind == KIND_TICK);
	assign btn_acc    = accept && (kind != KIND_TICK);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clocks_per_unit_q <= CLOCKS_PER_UNIT_RST;
		end else if (wr_en) begin
			clocks_per_unit_q <= wr_data;
		end
	end

	assign limit  = (clocks_per_unit_q == '0) ? PRESCALE_W'(1) : clocks_per_unit_q;
	assign pc_inc = prescale_q + PRESCALE_W'(1);

	// Decide the next control state from the word and the digit flags
	always_comb begin
		prescale_nxt   = prescale_q;
		is_running_nxt = is_running_q;
		dir_up_nxt     = dir_up_q;
		step           = 1'b0;
		cmd.clr        = 1'b0;
		if (tick_acc && is_running_q) begin
			if (!dir_up_q && links[NUM_DIGITS].zero) begin
				// already at zero running down: finish without counting
				is_running_nxt = 1'b0;
				dir_up_nxt     = 1'b1;
				prescale_nxt   = '0;
			end else if ((pc_inc >= limit) || (pc_inc == '0)) begin
				prescale_nxt = '0;
				step         = 1'b1;
				if (!dir_up_q && links[NUM_DIGITS].nxt_zero) begin
					is_running_nxt = 1'b0;
					dir_up_nxt     = 1'b1;
				end
			end else begin
				prescale_nxt = pc_inc;
			end
		end else if (btn_acc) begin
			unique case (button_code)
				BTN_UP:    dir_up_nxt     = 1'b1;
				BTN_START: is_running_nxt = 1'b1;
				BTN_STOP:  is_running_nxt = 1'b0;
				BTN_DOWN:  dir_up_nxt     = 1'b0;
				BTN_RESET: begin
					cmd.clr      = 1'b1;
					prescale_nxt = '0;
				end
				default: ;
			endcase
		end
		cmd.up = step && dir_up_q;
		cmd.dn = step && !dir_up_q;
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q   <= '0;
			is_running_q <= 1'b0;
			dir_up_q     <= 1'b1;
		end else begin
			prescale_q   <= prescale_nxt;
			is_running_q <= is_running_nxt;
			dir_up_q     <= dir_up_nxt;
		end
	end

	// Row of digit cells, least significant first
	assign links[0].carry    = step;
	assign links[0].zero     = 1'b1;
	assign links[0].nxt_zero = 1'b1;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		usw_digit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (links[i]),
			.link_out (links[i+1]),
			.value    (values[i])
		);
	end

	// Pick the shown digit; positions past the row show a zero
	always_comb begin
		shown = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (32'(digit_position) == i) begin
				shown = values[i];
			end
		end
	end

	assign segs = seg_of(shown);

	always_comb begin
		result_new.drive_word  = {(ENABLE_W'('1) ^ (ENABLE_W'(1) << digit_position)),
			(SEG_W'('1) ^ segs)};
		result_new.running     = is_running_nxt;
		result_new.counting_up = dir_up_nxt;
	end

	// Output buffer: output register with a skid register behind it
	assign out_load = !out_vld_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q  <= skid_vld_q || accept;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_vld_q ? skid_q : result_new;
		end
		if (!out_load && accept) begin
			skid_q <= result_new;
		end
	end

	assign result_valid = out_vld_q;
	assign drive_word   = out_q.drive_word;
	assign running      = out_q.running;
	assign counting_up  = out_q.counting_up;

	// Checks
	`USW_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q, "skid word without output word")
	`USW_ASSERT_NEXT(a_out_kept, out_vld_q && result_stall, out_vld_q, "stalled result dropped")
	`USW_ASSERT_NEXT(a_out_drains, out_vld_q && !result_stall && !skid_vld_q && !accept,
		!out_vld_q, "result word repeated")
	`USW_ASSERT_NEXT(a_stopped_holds, tick_acc && !is_running_q,
		prescale_q == $past(prescale_q), "prescaler moved while stopped")

endmodule

@@ tb/sv/usw_watch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch checker
// Watches both channels and the register port of the stopwatch, keeps its own
// copy of the time, prescaler, run state and direction, predicts the display
// word for every accepted input word and compares each result word with it.
// ----------------------------------------------------------------------------
module usw_watch_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [usw_pkg::PRESCALE_W-1:0] wr_data,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic                           kind,
	input  logic [usw_pkg::CODE_W-1:0]     button_code,
	input  logic [usw_pkg::POS_W-1:0]      digit_position,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic [usw_pkg::WORD_W-1:0]     drive_word,
	input  logic                           running,
	input  logic                           counting_up,
	output int unsigned                    mismatches,
	output int unsigned                    faces_owed
);
	import usw_pkg::*;

	localparam int DIGITS = 8;

	// Active-high segments g..a for 0..9
	localparam logic [SEG_W-1:0] FACE_SEGS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	digit_t                watch_bcd [DIGITS];
	logic [PRESCALE_W-1:0] tick_count;
	logic [PRESCALE_W-1:0] unit_clocks;
	logic                  is_counting;
	logic                  heading_up;
	usw_result_t           face_q [$];

	function automatic bit watch_at_zero();
		bit z;
		z = 1'b1;
		for (int i = 0; i < DIGITS; i++)
			if (watch_bcd[i] != 4'd0)
				z = 1'b0;
		return z;
	endfunction

	task automatic clear_watch();
		for (int i = 0; i < DIGITS; i++)
			watch_bcd[i] = 4'd0;
	endtask

	// Ripple one unit up, wrapping from all nines to zero
	task automatic watch_up();
		bit done;
		done = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (!done) begin
				if (watch_bcd[i] >= 4'd9) begin
					watch_bcd[i] = 4'd0;
				end else begin
					watch_bcd[i] = watch_bcd[i] + 4'd1;
					done = 1'b1;
				end
			end
		end
	endtask

	// Borrow one unit down
	task automatic watch_down();
		bit done;
		done = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (!done) begin
				if (watch_bcd[i] == 4'd0) begin
					watch_bcd[i] = 4'd9;
				end else begin
					watch_bcd[i] = watch_bcd[i] - 4'd1;
					done = 1'b1;
				end
			end
		end
	endtask

	// Countdown finished: stop, turn to up, drop the prescaler
	task automatic halt_at_zero();
		is_counting = 1'b0;
		heading_up  = 1'b1;
		tick_count  = '0;
	endtask

	// Apply one input word and queue the display word it shows afterwards
	task automatic advance_watch(input logic k, input logic [CODE_W-1:0] code,
			input logic [POS_W-1:0] pos);
		logic [PRESCALE_W-1:0] limit;
		logic [SEG_W-1:0]      segs;
		logic [ENABLE_W-1:0]   one_hot;
		digit_t                d;
		usw_result_t           face;
		limit = (unit_clocks == '0) ? PRESCALE_W'(1) : unit_clocks;
		if (k == KIND_TICK) begin
			if (is_counting) begin
				if (!heading_up && watch_at_zero()) begin
					halt_at_zero();
				end else begin
					tick_count = tick_count + 1'b1;
					if (!(tick_count < limit && tick_count != '0)) begin
						tick_count = '0;
						if (heading_up) begin
							watch_up();
						end else begin
							watch_down();
							if (watch_at_zero())
								halt_at_zero();
						end
					end
				end
			end
		end else begin
			case (code)
				BTN_UP:    heading_up = 1'b1;
				BTN_START: is_counting = 1'b1;
				BTN_STOP:  is_counting = 1'b0;
				BTN_DOWN:  heading_up = 1'b0;
				BTN_RESET: begin
					clear_watch();
					tick_count = '0;
				end
				default: ;
			endcase
		end
		d       = watch_bcd[pos];
		segs    = (d <= 4'd9) ? FACE_SEGS[d] : FACE_SEGS[0];
		one_hot = ENABLE_W'(1) << pos;
		face.drive_word  = {~one_hot, ~segs};
		face.running     = is_counting;
		face.counting_up = heading_up;
		face_q.push_back(face);
	endtask

	// Compare accepted results, then track register writes and input words
	always @(posedge clk or negedge arst_n) begin
		usw_result_t want;
		if (!arst_n) begin
			clear_watch();
			tick_count  = '0;
			unit_clocks = CLOCKS_PER_UNIT_RST;
			is_counting = 1'b0;
			heading_up  = 1'b1;
			face_q.delete();
			mismatches  = 0;
			faces_owed <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (face_q.size() == 0) begin
					$error("result word with none expected: drive_word %h", drive_word);
					mismatches++;
				end else begin
					want = face_q.pop_front();
					if (drive_word !== want.drive_word) begin
						$error("drive_word: expected %h, got %h", want.drive_word, drive_word);
						mismatches++;
					end
					if (running !== want.running) begin
						$error("running: expected %b, got %b", want.running, running);
						mismatches++;
					end
					if (counting_up !== want.counting_up) begin
						$error("counting_up: expected %b, got %b", want.counting_up,
							counting_up);
						mismatches++;
					end
				end
			end
			if (wr_en)
				unit_clocks = wr_data;
			if (item_valid && !item_stall)
				advance_watch(kind, button_code, digit_position);
			faces_owed <= face_q.size();
		end
	end

endmodule

@@ tb/sv/up_down_stopwatch_seven_segment_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch testbench
// Drives tick and button words into the stopwatch under several prescaler
// settings with random gaps and result back-pressure; a checker beside the
// block predicts every display word and counts the mismatches.
// ----------------------------------------------------------------------------
module up_down_stopwatch_seven_segment_unit_tb;
	import usw_pkg::*;

	localparam logic KIND_BUTTON  = ~KIND_TICK;
	localparam int   QUIET_LIMIT  = 2000;
	localparam int   PHASE_WORDS  = 105;
	localparam int   PHASES       = 8;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  wr_en          = 1'b0;
	logic [PRESCALE_W-1:0] wr_data        = '0;
	logic                  item_valid     = 1'b0;
	logic                  item_stall;
	logic                  kind           = KIND_TICK;
	logic [CODE_W-1:0]     button_code    = '0;
	logic [POS_W-1:0]      digit_position = '0;
	logic                  result_valid;
	logic                  result_stall   = 1'b0;
	logic [WORD_W-1:0]     drive_word;
	logic                  running;
	logic                  counting_up;

	int unsigned mismatches;
	int unsigned faces_owed;
	int          quiet_cycles = 0;
	int          stall_left   = 0;
	bit          calm         = 1'b0;

	up_down_stopwatch_seven_segment_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_data        (wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.button_code    (button_code),
		.digit_position (digit_position),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.drive_word     (drive_word),
		.running        (running),
		.counting_up    (counting_up)
	);

	usw_watch_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_data        (wr_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.button_code    (button_code),
		.digit_position (digit_position),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.drive_word     (drive_word),
		.running        (running),
		.counting_up    (counting_up),
		.mismatches     (mismatches),
		.faces_owed     (faces_owed)
	);

	always #5 clk = ~clk;

	// Result back-pressure: runs of open and stalled cycles, some long
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 60) begin
			result_stall <= 1'b0;
			stall_left   <= $urandom_range(0, 4);
		end else begin
			result_stall <= 1'b1;
			stall_left   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
				: $urandom_range(15, 60);
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("up_down_stopwatch_seven_segment_unit_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly real buttons, start favoured so the watch spends time counting
	function automatic logic [CODE_W-1:0] pick_button();
		int r;
		r = $urandom_range(0, 99);
		if (r < 28) return BTN_START;
		if (r < 38) return BTN_STOP;
		if (r < 53) return BTN_UP;
		if (r < 70) return BTN_DOWN;
		if (r < 82) return BTN_RESET;
		return CODE_W'($urandom_range(0, 31));
	endfunction

	// Present one word, hold it until taken, then maybe leave a gap
	task automatic send_word(input logic k, input logic [CODE_W-1:0] code,
			input logic [POS_W-1:0] pos);
		int gap;
		kind           <= k;
		button_code    <= code;
		digit_position <= pos;
		item_valid     <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every display word has come back
	task automatic drain();
		if (item_valid)
			item_valid <= 1'b0;
		@(negedge clk);
		while (faces_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_unit_clocks(input logic [PRESCALE_W-1:0] v);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en   <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [PRESCALE_W-1:0] settings [PHASES];
		settings = '{20'd1, 20'd3, 20'd0, 20'd2, 20'hFFFFF, 20'd1,
			PRESCALE_W'($urandom_range(1, 6)), 20'd7};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset prescaler: codes ignored on ticks, stray codes, start then run down
		send_word(KIND_TICK, '1, 3'd0);
		send_word(KIND_BUTTON, '0, 3'd7);
		send_word(KIND_BUTTON, BTN_UP | BTN_START, 3'd1);
		send_word(KIND_BUTTON, '1, 3'd2);
		send_word(KIND_BUTTON, BTN_START, 3'd3);
		send_word(KIND_TICK, '0, 3'd4);
		send_word(KIND_BUTTON, BTN_DOWN, 3'd5);
		send_word(KIND_TICK, '0, 3'd6);
		send_word(KIND_BUTTON, BTN_STOP, 3'd0);
		send_word(KIND_BUTTON, BTN_RESET, 3'd0);
		drain();

		// One unit per tick: count up three, then down to zero and stop
		write_unit_clocks(20'd1);
		send_word(KIND_BUTTON, BTN_START, 3'd0);
		repeat (3) send_word(KIND_TICK, '0, 3'd0);
		send_word(KIND_BUTTON, BTN_DOWN, 3'd1);
		repeat (3) send_word(KIND_TICK, '0, 3'd0);
		send_word(KIND_TICK, '0, 3'd0);
		drain();

		// Shrink the prescale limit under a running prescaler
		write_unit_clocks(20'hFFFFF);
		send_word(KIND_BUTTON, BTN_START, 3'd0);
		repeat (3) send_word(KIND_TICK, '0, 3'd0);
		drain();
		write_unit_clocks(20'd2);
		send_word(KIND_TICK, '0, 3'd0);
		send_word(KIND_TICK, '0, 3'd0);
		send_word(KIND_BUTTON, BTN_STOP, 3'd0);
		drain();

		// Random words under each setting, some phases without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 1) || (ph == 4);
			write_unit_clocks(settings[ph]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(0, 99) < 72)
					send_word(KIND_TICK, CODE_W'($urandom), POS_W'($urandom));
				else
					send_word(KIND_BUTTON, pick_button(), POS_W'($urandom));
			end
			drain();
		end

		calm = 1'b0;
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("up_down_stopwatch_seven_segment_unit_tb: done, clean");
		else
			$display("up_down_stopwatch_seven_segment_unit_tb: done, errors");
		$finish;
	end

endmodule
